// ===== rtl/core/lcap_pkg.sv =====
// Types, codes and sentence patterns for the NMEA line capture block.
// No dependencies; used by lcap_ctrl and nmea_rmc_gga_line_capture.
package lcap_pkg;

    typedef enum logic [1:0] {
        OP_RECEIVE = 2'd0,
        OP_READ    = 2'd1,
        OP_RELEASE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        SEEK_RMC   = 2'd0,
        SEEK_GGA   = 2'd1,
        PAIR_READY = 2'd2
    } hunt_t;

    typedef struct packed {
        hunt_t capture_state;
        logic  line_ended;
        logic  line_matched;
    } rx_result_t;

    localparam logic [7:0] LF_BYTE   = 8'h0A;
    localparam logic [7:0] NUL_BYTE  = 8'h00;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam int         PREFIX_LEN = 6;
    localparam int         TALKER_POS = 2;

    // Expected byte of "$G?RMC" (gga = 0) or "$G?GGA" (gga = 1).
    function automatic logic [7:0] pattern_byte(input logic gga, input logic [2:0] idx);
        logic [7:0] b;
        b = NUL_BYTE;
        case (idx)
            3'd0: b = CH_DOLLAR;
            3'd1: b = CH_G;
            3'd3: b = gga ? CH_G : CH_R;
            3'd4: b = gga ? CH_G : CH_M;
            3'd5: b = gga ? CH_A : CH_C;
            default: b = NUL_BYTE;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/core/lcap_bank.sv =====
// One bank of line storage: synchronous write, registered read.
// No dependencies; instantiated twice by nmea_rmc_gga_line_capture.
module lcap_bank #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    q
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            q <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/lcap_ctrl.sv =====
// Line assembly, prefix match and hunt sequencing; drives bank write ports.
// Depends on lcap_pkg.
module lcap_ctrl #(
    parameter int LINE_DEPTH      = 128,
    parameter int MAX_LINE_LENGTH = 120,
    parameter int PW              = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  lcap_pkg::op_t        op,
    input  logic [7:0]           rx_byte,
    output logic                 we0,
    output logic [PW-1:0]        waddr0,
    output logic [7:0]           wdata0,
    output logic                 we1,
    output logic [PW-1:0]        waddr1,
    output logic [7:0]           wdata1,
    output lcap_pkg::rx_result_t result
);

    localparam int LW = $clog2(MAX_LINE_LENGTH + 2);
    localparam int AW = ((LW > PW) ? LW : PW) + 1;

    lcap_pkg::hunt_t hunt_reg, hunt_next;
    logic [LW-1:0]   line_len_reg, line_len_next;
    logic            prefix_ok_reg, prefix_ok_next;

    logic          is_receive, overlong, rx_go, is_lf, pat_fail, prefix_new, matched;
    logic          byte_ok, term_ok, buf_sel;
    logic [AW-1:0] pos_ext, term_ext;

    always_comb
    begin
        is_receive = accept && (op == lcap_pkg::OP_RECEIVE)
                     && (hunt_reg != lcap_pkg::PAIR_READY);
        overlong   = line_len_reg > LW'(MAX_LINE_LENGTH);
        rx_go      = is_receive && !overlong;
        is_lf      = rx_byte == lcap_pkg::LF_BYTE;
        pos_ext    = AW'(line_len_reg);
        term_ext   = pos_ext + AW'(1);
        pat_fail   = (pos_ext < AW'(lcap_pkg::PREFIX_LEN))
                     && (pos_ext != AW'(lcap_pkg::TALKER_POS))
                     && (rx_byte != lcap_pkg::pattern_byte(hunt_reg == lcap_pkg::SEEK_GGA,
                                                           line_len_reg[2:0]));
        prefix_new = prefix_ok_reg && !pat_fail;
        matched    = rx_go && is_lf && prefix_new
                     && (pos_ext >= AW'(lcap_pkg::PREFIX_LEN - 1));
    end

    always_comb
    begin
        hunt_next      = hunt_reg;
        line_len_next  = line_len_reg;
        prefix_ok_next = prefix_ok_reg;
        if (is_receive && overlong)
        begin
            line_len_next  = '0;
            prefix_ok_next = 1'b1;
        end
        else if (rx_go)
        begin
            if (is_lf)
            begin
                line_len_next  = '0;
                prefix_ok_next = 1'b1;
                if (matched)
                begin
                    hunt_next = (hunt_reg == lcap_pkg::SEEK_RMC) ? lcap_pkg::SEEK_GGA
                                                                 : lcap_pkg::PAIR_READY;
                end
            end
            else
            begin
                line_len_next  = line_len_reg + LW'(1);
                prefix_ok_next = prefix_new;
            end
        end
        else if (accept && (op == lcap_pkg::OP_RELEASE) && (hunt_reg == lcap_pkg::PAIR_READY))
        begin
            hunt_next = lcap_pkg::SEEK_RMC;
        end
    end

    // Byte and terminator land in opposite banks, so both go out in the same cycle.
    always_comb
    begin
        buf_sel = hunt_reg == lcap_pkg::SEEK_GGA;
        byte_ok = pos_ext < AW'(LINE_DEPTH);
        term_ok = is_lf && (term_ext < AW'(LINE_DEPTH));
        if (!pos_ext[0])
        begin
            we0    = rx_go && byte_ok;
            waddr0 = {buf_sel, pos_ext[PW-1:1]};
            wdata0 = rx_byte;
            we1    = rx_go && term_ok;
            waddr1 = {buf_sel, term_ext[PW-1:1]};
            wdata1 = lcap_pkg::NUL_BYTE;
        end
        else
        begin
            we0    = rx_go && term_ok;
            waddr0 = {buf_sel, term_ext[PW-1:1]};
            wdata0 = lcap_pkg::NUL_BYTE;
            we1    = rx_go && byte_ok;
            waddr1 = {buf_sel, pos_ext[PW-1:1]};
            wdata1 = rx_byte;
        end
        result.capture_state = hunt_next;
        result.line_ended    = rx_go && is_lf;
        result.line_matched  = matched;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hunt_reg      <= lcap_pkg::SEEK_RMC;
            line_len_reg  <= '0;
            prefix_ok_reg <= 1'b1;
        end
        else
        begin
            hunt_reg      <= hunt_next;
            line_len_reg  <= line_len_next;
            prefix_ok_reg <= prefix_ok_next;
        end
    end

endmodule

// ===== rtl/core/nmea_rmc_gga_line_capture.sv =====
// Top level of the NMEA RMC/GGA line capture: handshake, read path, result stage.
// Depends on lcap_pkg, lcap_bank and lcap_ctrl.
//
//  channel  dir  payload                                  transfer when
//  s_       in   tuser: operation; tdata: rx_byte,        s_tvalid && s_tready
//                read_buffer, read_index
//  m_       out  tdata: capture_state, read_data;         m_tvalid && m_tready
//                tuser: line_ended, line_matched
//
// One item per cycle while the result stage is not stalled; each result appears in the
// cycle after its transfer, from the registered read of the line banks. Both lines live
// in two banks split on the low position bit, so a line feed and its zero terminator
// are written in the same cycle. A stalled result holds the stage and s_tready drops.
// Reset clears the line length, hunt state and valid flag; stored bytes stay
// undefined until written. LINE_DEPTH must be even.
module nmea_rmc_gga_line_capture #(
    parameter int LINE_DEPTH      = 128,
    parameter int MAX_LINE_LENGTH = 120
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // rx_byte[7:0], read_buffer[8], read_index[15:9]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // capture_state[1:0], read_data[9:2], zero[15:10]
    output logic [1:0]  m_tuser    // line_ended[0], line_matched[1]
);

    localparam int PW = $clog2(LINE_DEPTH);
    localparam int RW = ((PW > 7) ? PW : 7) + 1;

    logic          accept;
    lcap_pkg::op_t op;
    logic [7:0]    rx_byte;
    logic          read_buffer;
    logic [6:0]    read_index;
    logic [RW-1:0] ridx_ext;
    logic          rd_ok, re0, re1;
    logic [PW-1:0] raddr;

    logic          we0, we1;
    logic [PW-1:0] waddr0, waddr1;
    logic [7:0]    wdata0, wdata1, q0, q1;

    lcap_pkg::rx_result_t result;

    logic                 valid_reg;
    lcap_pkg::rx_result_t res_reg;
    logic                 rd_reg;
    logic                 bank_reg;
    logic [7:0]           read_data;

    assign s_tready    = !valid_reg || m_tready;
    assign accept      = s_tvalid && s_tready;
    assign op          = lcap_pkg::op_t'(s_tuser);
    assign rx_byte     = s_tdata[7:0];
    assign read_buffer = s_tdata[8];
    assign read_index  = s_tdata[15:9];

    always_comb
    begin
        ridx_ext = RW'(read_index);
        rd_ok    = accept && (op == lcap_pkg::OP_READ) && (ridx_ext < RW'(LINE_DEPTH));
        raddr    = {read_buffer, ridx_ext[PW-1:1]};
        re0      = rd_ok && !ridx_ext[0];
        re1      = rd_ok && ridx_ext[0];
    end

    lcap_ctrl #(
        .LINE_DEPTH      (LINE_DEPTH),
        .MAX_LINE_LENGTH (MAX_LINE_LENGTH),
        .PW              (PW)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .op      (op),
        .rx_byte (rx_byte),
        .we0     (we0),
        .waddr0  (waddr0),
        .wdata0  (wdata0),
        .we1     (we1),
        .waddr1  (waddr1),
        .wdata1  (wdata1),
        .result  (result)
    );

    lcap_bank #(
        .DEPTH (2 ** PW),
        .AW    (PW)
    ) u_bank_even (
        .clk   (clk),
        .we    (we0),
        .waddr (waddr0),
        .wdata (wdata0),
        .re    (re0),
        .raddr (raddr),
        .q     (q0)
    );

    lcap_bank #(
        .DEPTH (2 ** PW),
        .AW    (PW)
    ) u_bank_odd (
        .clk   (clk),
        .we    (we1),
        .waddr (waddr1),
        .wdata (wdata1),
        .re    (re1),
        .raddr (raddr),
        .q     (q1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg  <= result;
            rd_reg   <= rd_ok;
            bank_reg <= ridx_ext[0];
        end
    end

    always_comb
    begin
        read_data = '0;
        if (rd_reg)
        begin
            read_data = bank_reg ? q1 : q0;
        end
        m_tvalid = valid_reg;
        m_tdata  = {6'd0, read_data, res_reg.capture_state};
        m_tuser  = {res_reg.line_matched, res_reg.line_ended};
    end

endmodule
